// ----- sv/nia_pkg.sv -----
// ----------------------------------------------------------------------------
// nia_pkg
// Shared types and codes for the node ID slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package nia_pkg;

  localparam int ID_W     = 16;
  localparam int SLOT_F_W = 5;   // slot_index field width
  localparam int USED_F_W = 6;   // entries_used field width
  localparam int STAT_W   = 3;

  // status codes
  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd0;
  localparam logic [STAT_W-1:0] ST_ADDED     = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_IGNORED   = 3'd4;

  // opcodes
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // request word
  typedef struct packed {
    logic            opcode;
    logic [ID_W-1:0] node_id_in;
    logic            already_indexed;
  } req_t;

  // result word
  typedef struct packed {
    logic [SLOT_F_W-1:0] slot_index;
    logic [STAT_W-1:0]   status;
    logic [USED_F_W-1:0] entries_used;
  } res_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic            active;
    logic            add;       // place the ID if absent
    logic            hit;       // match seen upstream
    logic            free_hit;  // free slot seen upstream
    logic [ID_W-1:0] id;
  } tok_t;

endpackage

`default_nettype wire

// ----- sv/node_id_index_allocator.sv -----
// ----------------------------------------------------------------------------
// node_id_index_allocator
// Node ID table with lookup, lowest-free-slot insert, and full detection.
// ----------------------------------------------------------------------------
// Usage: raise start with a request word while busy is low. Exactly one
// result word follows, shown for one cycle with done high; the receiver
// cannot stall it and must take it in that cycle. Ignored requests (ID zero
// or already indexed) and requests for this node's own ID answer in the
// cycle after acceptance and never raise busy. All other requests run a
// search token down a row of NUM_SLOTS-1 slot cells, one cell per cycle;
// busy stays high while the token is in the row and drops as the result
// word is shown. The next word can be taken once busy is low, so only one
// request is in hand at a time and the row length sets the rate. Slot zero
// lives in the own_id register, written over the cfg channel, which is
// ready whenever busy is low.
// Reset empties every slot and sets own_id to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module node_id_index_allocator import nia_pkg::*; #(
  parameter int NUM_SLOTS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  // request
  input  wire logic            start,
  output logic                 busy,
  input  wire req_t            req,
  // result
  output logic                 done,
  output res_t                 res,
  // own_id write channel
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [ID_W-1:0] cfg_data
);

  localparam int SLOT_W  = (NUM_SLOTS > 2) ? $clog2(NUM_SLOTS) : 1;
  localparam int COUNT_W = $clog2(NUM_SLOTS + 1);
  localparam int CELLS   = NUM_SLOTS - 1;

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t             state;
  logic [ID_W-1:0]    own_id;
  logic [COUNT_W-1:0] count;
  tok_t               tok_head;

  // token chain taps: index 0 is the head register, k is cell k's output
  tok_t               tok       [CELLS+1];
  logic [SLOT_W-1:0]  hit_slot  [CELLS+1];
  logic [SLOT_W-1:0]  free_slot [CELLS+1];

  logic               wr_en;
  logic [SLOT_W-1:0]  wr_slot;
  logic               accept;
  logic               ignored;
  tok_t               tail;

  assign busy      = (state == S_SCAN);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign ignored   = (req.node_id_in == '0) || req.already_indexed;
  assign tail      = tok[CELLS];

  // insert happens as the token leaves the last cell
  assign wr_en   = busy && tail.active && !tail.hit && tail.add && tail.free_hit;
  assign wr_slot = free_slot[CELLS];

  assign tok[0]       = tok_head;
  assign hit_slot[0]  = '0;
  assign free_slot[0] = '0;

  genvar g;
  generate
    for (g = 1; g <= CELLS; g++) begin : g_cell
      nia_cell #(
        .SLOT_W (SLOT_W),
        .SLOT   (g)
      ) u_cell (
        .clk           (clk),
        .rst           (rst),
        .tok_in        (tok[g-1]),
        .hit_slot_in   (hit_slot[g-1]),
        .free_slot_in  (free_slot[g-1]),
        .tok_out       (tok[g]),
        .hit_slot_out  (hit_slot[g]),
        .free_slot_out (free_slot[g]),
        .wr_en         (wr_en),
        .wr_slot       (wr_slot),
        .wr_id         (tail.id)
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      own_id          <= 16'd1;
      count           <= COUNT_W'(1);
      done            <= 1'b0;
      tok_head.active <= 1'b0;
    end else begin
      done            <= 1'b0;
      tok_head.active <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        own_id <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (ignored) begin
              done             <= 1'b1;
              res.slot_index   <= '0;
              res.status       <= ST_IGNORED;
              res.entries_used <= USED_F_W'(count);
            end else if (req.node_id_in == own_id) begin
              // slot zero checked here, ahead of the row
              done             <= 1'b1;
              res.slot_index   <= '0;
              res.status       <= ST_FOUND;
              res.entries_used <= USED_F_W'(count);
            end else begin
              tok_head.active   <= 1'b1;
              tok_head.add      <= (req.opcode == OP_ADD);
              tok_head.hit      <= 1'b0;
              tok_head.free_hit <= 1'b0;
              tok_head.id       <= req.node_id_in;
              state             <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (tail.active) begin
            done  <= 1'b1;
            state <= S_IDLE;
            if (tail.hit) begin
              res.slot_index   <= SLOT_F_W'(hit_slot[CELLS]);
              res.status       <= ST_FOUND;
              res.entries_used <= USED_F_W'(count);
            end else if (!tail.add) begin
              res.slot_index   <= '0;
              res.status       <= ST_NOT_FOUND;
              res.entries_used <= USED_F_W'(count);
            end else if (tail.free_hit) begin
              count            <= count + COUNT_W'(1);
              res.slot_index   <= SLOT_F_W'(free_slot[CELLS]);
              res.status       <= ST_ADDED;
              res.entries_used <= USED_F_W'(count + COUNT_W'(1));
            end else begin
              res.slot_index   <= '0;
              res.status       <= ST_FULL;
              res.entries_used <= USED_F_W'(count);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/nia_cell.sv -----
// ----------------------------------------------------------------------------
// nia_cell
// One table slot: holds an ID, checks the passing token, forwards it.
// ----------------------------------------------------------------------------
`default_nettype none

module nia_cell import nia_pkg::*; #(
  parameter int SLOT_W = 5,
  parameter int SLOT   = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tok_t              tok_in,
  input  wire logic [SLOT_W-1:0] hit_slot_in,
  input  wire logic [SLOT_W-1:0] free_slot_in,
  output tok_t                   tok_out,
  output logic      [SLOT_W-1:0] hit_slot_out,
  output logic      [SLOT_W-1:0] free_slot_out,
  input  wire logic              wr_en,
  input  wire logic [SLOT_W-1:0] wr_slot,
  input  wire logic [ID_W-1:0]   wr_id
);

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(SLOT);

  logic [ID_W-1:0]   id;
  tok_t              tok_next;
  logic [SLOT_W-1:0] hit_slot_next;
  logic [SLOT_W-1:0] free_slot_next;

  always_comb begin
    tok_next       = tok_in;
    hit_slot_next  = hit_slot_in;
    free_slot_next = free_slot_in;
    if (tok_in.active && !tok_in.hit && id == tok_in.id) begin
      tok_next.hit  = 1'b1;
      hit_slot_next = MY_SLOT;
    end
    if (tok_in.active && !tok_in.free_hit && id == '0) begin
      tok_next.free_hit = 1'b1;
      free_slot_next    = MY_SLOT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id             <= '0;
      tok_out.active <= 1'b0;
    end else begin
      if (wr_en && wr_slot == MY_SLOT) begin
        id <= wr_id;
      end
      tok_out <= tok_next;
    end
    hit_slot_out  <= hit_slot_next;
    free_slot_out <= free_slot_next;
  end

endmodule

`default_nettype wire

// ----- sv/nia_checker.sv -----
// ----------------------------------------------------------------------------
// nia_checker
// Port-level checks for the node ID slot allocator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module nia_checker import nia_pkg::*; (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            start,
  input wire logic            busy,
  input wire req_t            req,
  input wire logic            done,
  input wire res_t            res,
  input wire logic            cfg_valid,
  input wire logic            cfg_ready,
  input wire logic [ID_W-1:0] cfg_data
);

  // an ignored request answers in the very next cycle
  a_ignored: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.node_id_in == '0 || req.already_indexed))
    |=> (done && res.status == ST_IGNORED))
    else $error("ignored request not answered next cycle");

  // slot is zero unless found or added
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (done && res.status != ST_FOUND && res.status != ST_ADDED)
    |-> (res.slot_index == '0))
    else $error("nonzero slot with failure status");

  // no status code outside the defined set
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (res.status == ST_FOUND || res.status == ST_ADDED ||
              res.status == ST_FULL || res.status == ST_NOT_FOUND ||
              res.status == ST_IGNORED))
    else $error("undefined status code");

  // busy only starts after an accepted request
  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

endmodule

bind node_id_index_allocator nia_checker u_nia_checker (.*);

`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the node ID slot allocator. A short table of
// requests covers reset state, ID extremes, ignored words and first inserts.
// Random requests follow in phases under a changing own ID. A shadow
// table predicts every result word, and a monitor compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import nia_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS    = 32;
  localparam int PHASE_WORDS  = 250;
  localparam int PHASES       = 6;

  logic            clk = 1'b0;
  logic            rst;
  logic            start;
  logic            busy;
  req_t            req;
  logic            done;
  res_t            res;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [ID_W-1:0] cfg_data;

  node_id_index_allocator #(.NUM_SLOTS(NUM_SLOTS)) uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b0;
    #1 clk = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Shadow of the slot table. Slots fill from the bottom and are never freed,
  // so slots 0..used_slots-1 are exactly the occupied ones.
  // --------------------------------------------------------------------------
  logic [ID_W-1:0] shadow_ids [NUM_SLOTS];
  int              used_slots;

  res_t pending_results [$];   // expected result words, oldest first
  int   err_count;
  int   words_sent;
  int   status_seen [5];       // per status code, counted on the result side
  int   own_writes;

  // Predict one request and apply it to the shadow table.
  function automatic res_t model_lookup_insert(input req_t r);
    res_t o;
    int   hit;
    int   free_slot;
    hit       = -1;
    free_slot = -1;
    o.slot_index = '0;
    if (r.node_id_in == '0 || r.already_indexed) begin
      o.status = ST_IGNORED;
    end else begin
      // lowest matching slot wins, slot zero included
      for (int i = 0; i < NUM_SLOTS; i++)
        if (hit < 0 && shadow_ids[i] == r.node_id_in) hit = i;
      if (hit >= 0) begin
        o.slot_index = SLOT_F_W'(hit);
        o.status     = ST_FOUND;
      end else if (r.opcode == OP_LOOKUP) begin
        o.status = ST_NOT_FOUND;
      end else begin
        for (int i = 1; i < NUM_SLOTS; i++)
          if (free_slot < 0 && shadow_ids[i] == '0) free_slot = i;
        if (free_slot < 0) begin
          o.status = ST_FULL;
        end else begin
          shadow_ids[free_slot] = r.node_id_in;
          used_slots++;
          o.slot_index = SLOT_F_W'(free_slot);
          o.status     = ST_ADDED;
        end
      end
    end
    o.entries_used = USED_F_W'(used_slots);
    return o;
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // --------------------------------------------------------------------------
  // Result monitor. done is a one-cycle strobe; sampled at the rising edge,
  // so the values seen are those of the cycle that the edge ends.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word slot=%0d status=%0d used=%0d",
                                  res.slot_index, res.status, res.entries_used));
      end else begin
        want = pending_results.pop_front();
        if (res.slot_index !== want.slot_index)
          report_mismatch($sformatf("slot_index %0d, want %0d",
                                    res.slot_index, want.slot_index));
        if (res.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", res.status, want.status));
        if (res.entries_used !== want.entries_used)
          report_mismatch($sformatf("entries_used %0d, want %0d",
                                    res.entries_used, want.entries_used));
        if (want.status <= ST_IGNORED) status_seen[want.status]++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  // Idle length after an accepted word: mostly none or short, a few long
  // enough to land anywhere inside a full search.
  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 88) return $urandom_range(1, 3);
    return $urandom_range(4, NUM_SLOTS + 12);
  endfunction

  // Present one word, wait for it to be taken, log the expectation.
  // With use_lit set the typed-in word is expected instead of the prediction;
  // the shadow table is still updated.
  task automatic send_request(input req_t r, input bit use_lit, input res_t lit,
                              input bit may_idle);
    res_t pred;
    int   gap;
    @(negedge clk);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy !== 1'b0);
    pred = model_lookup_insert(r);
    pending_results.push_back(use_lit ? lit : pred);
    words_sent++;
    gap = may_idle ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      req   <= req_t'($urandom());   // junk on the bus while idle
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Random request, biased toward IDs already in the table so that hits are
  // common; fresh inserts are rare so that the table fills part way through.
  function automatic req_t gen_request();
    req_t r;
    int   k;
    r.opcode          = logic'($urandom_range(0, 1));
    r.node_id_in      = ID_W'($urandom_range(1, 65535));
    r.already_indexed = 1'b0;
    k = $urandom_range(0, 99);
    if (k < 10) begin
      // noise: empty ID or an already-indexed requester
      if ($urandom_range(0, 1)) r.node_id_in = '0;
      else r.already_indexed = 1'b1;
    end else if (k < 60) begin
      r.node_id_in = shadow_ids[$urandom_range(0, used_slots - 1)];
    end else if (k < 95) begin
      r.opcode = OP_LOOKUP;
    end else begin
      r.opcode = OP_ADD;
    end
    return r;
  endfunction

  // Wait for the block to drain, then write own_id on the config channel.
  task automatic write_own_id(input logic [ID_W-1:0] val);
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (NUM_SLOTS + 2) @(posedge clk);
    repeat ($urandom_range(0, 4)) @(negedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    shadow_ids[0] = val;   // slot zero follows the write at once
    own_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= ID_W'($urandom());
  endtask

  // --------------------------------------------------------------------------
  // Directed table. Rows with lit set carry a result readable at a glance
  // (reset state, extremes, ignored words, first inserts); the rest rely on
  // the prediction.
  // --------------------------------------------------------------------------
  typedef struct {
    req_t r;
    bit   lit;
    res_t want;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic void add_row(input logic op, input logic [ID_W-1:0] id,
                                  input logic idx, input bit lit,
                                  input int slot, input logic [STAT_W-1:0] st,
                                  input int used);
    dir_row_t d;
    d.r.opcode             = op;
    d.r.node_id_in         = id;
    d.r.already_indexed    = idx;
    d.lit                  = lit;
    d.want.slot_index      = SLOT_F_W'(slot);
    d.want.status          = st;
    d.want.entries_used    = USED_F_W'(used);
    dir_rows.push_back(d);
  endfunction

  initial begin
    req_t            r;
    res_t            none;
    logic [ID_W-1:0] own_val;

    rst        = 1'b1;
    start      = 1'b0;
    req        = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    none       = '0;
    err_count  = 0;
    words_sent = 0;
    own_writes = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (shadow_ids[i]) shadow_ids[i] = '0;
    shadow_ids[0] = 16'd1;   // own_id comes out of reset as 1
    used_slots    = 1;

    // own ID right after reset
    add_row(OP_LOOKUP, 16'h0001, 1'b0, 1, 0, ST_FOUND,     1);
    add_row(OP_ADD,    16'h0001, 1'b0, 1, 0, ST_FOUND,     1);
    add_row(OP_LOOKUP, 16'h0005, 1'b0, 1, 0, ST_NOT_FOUND, 1);
    // ignored: empty ID or already indexed, either opcode
    add_row(OP_ADD,    16'h0000, 1'b0, 1, 0, ST_IGNORED,   1);
    add_row(OP_LOOKUP, 16'h0000, 1'b0, 1, 0, ST_IGNORED,   1);
    add_row(OP_ADD,    16'hFFFF, 1'b1, 1, 0, ST_IGNORED,   1);
    add_row(OP_LOOKUP, 16'hFFFF, 1'b1, 1, 0, ST_IGNORED,   1);
    add_row(OP_ADD,    16'h0000, 1'b1, 1, 0, ST_IGNORED,   1);
    // first inserts take the lowest free slots
    add_row(OP_ADD,    16'hFFFF, 1'b0, 1, 1, ST_ADDED,     2);
    add_row(OP_ADD,    16'hFFFF, 1'b0, 1, 1, ST_FOUND,     2);
    add_row(OP_LOOKUP, 16'hFFFF, 1'b0, 1, 1, ST_FOUND,     2);
    add_row(OP_ADD,    16'h8000, 1'b0, 1, 2, ST_ADDED,     3);
    add_row(OP_ADD,    16'h0002, 1'b0, 1, 3, ST_ADDED,     4);
    add_row(OP_LOOKUP, 16'h7FFF, 1'b0, 1, 0, ST_NOT_FOUND, 4);
    add_row(OP_ADD,    16'h5555, 1'b1, 1, 0, ST_IGNORED,   4);
    add_row(OP_ADD,    16'hAAAA, 1'b0, 0, 0, ST_FOUND,     0);
    add_row(OP_LOOKUP, 16'hAAAA, 1'b0, 0, 0, ST_FOUND,     0);
    add_row(OP_LOOKUP, 16'h5555, 1'b0, 0, 0, ST_FOUND,     0);
    add_row(OP_ADD,    16'h5555, 1'b0, 0, 0, ST_FOUND,     0);
    add_row(OP_LOOKUP, 16'h0001, 1'b0, 0, 0, ST_FOUND,     0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_request(dir_rows[i].r, dir_rows[i].lit, dir_rows[i].want, 1'b1);

    // Random phases under own_id in turn: the reset value one, zero (slot
    // zero never matches), all ones (shadows the stored 16'hFFFF entry, lowest
    // slot wins), a copy of a stored ID, a random value, and back to one.
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        case (ph)
          1:       own_val = 16'h0000;
          2:       own_val = 16'hFFFF;
          3:       own_val = shadow_ids[used_slots - 1];
          4:       own_val = ID_W'($urandom_range(1, 65535));
          default: own_val = 16'h0001;
        endcase
        write_own_id(own_val);
      end
      // phase 2 runs back to back with no idle cycles
      for (int n = 0; n < PHASE_WORDS; n++) begin
        r = gen_request();
        send_request(r, 1'b0, none, ph != 2);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // catch any stray word a full search later
    repeat (NUM_SLOTS + 8) @(posedge clk);

    $display("ran %0d requests over %0d own_id settings, table at %0d of %0d slots",
             words_sent, own_writes + 1, used_slots, NUM_SLOTS);
    $display("found %0d, added %0d, full %0d, not found %0d, ignored %0d",
             status_seen[ST_FOUND], status_seen[ST_ADDED], status_seen[ST_FULL],
             status_seen[ST_NOT_FOUND], status_seen[ST_IGNORED]);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2_000_000;
    $display("timeout");
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
